// File: rtl/core/rtnb_pkg.sv
// Shared types, constants and helpers of the radix tree node builder.
`default_nettype none
package rtnb_pkg;

  localparam int KEY_W      = 64;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int OFF_W      = CNT_W + 1;
  localparam int POS_W      = CNT_W + 3;
  localparam int DELTA_W    = 8;
  localparam int LZC_W      = 7;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_USED_W = 4 * IDX_W + 2;
  localparam int OUT_DATA_W = 48;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_BUILD = 1'b1;

  localparam logic [CNT_W-1:0] MIN_LEAVES = 11'd2;

  typedef logic signed [DELTA_W-1:0] delta_t;

  localparam delta_t DELTA_NONE = -8'sd1;
  localparam delta_t TIE_BONUS  = 8'sd32;

  typedef struct packed {
    logic             inr;
    logic [CNT_W-1:0] i;
    logic [CNT_W-1:0] j;
  } probe_t;

  function automatic logic [LZC_W-1:0] lzc64(input logic [KEY_W-1:0] v);
    logic [LZC_W-1:0] c;
    c = LZC_W'(KEY_W);
    for (int k = 0; k < KEY_W; k++) begin
      if (v[k]) c = LZC_W'(KEY_W - 1 - k);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rtnb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rtnb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/rtnb_delta.sv
// Prefix length unit: common prefix of two keys, index tie-break, -1 outside the range.
`default_nettype none
module rtnb_delta
  import rtnb_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [KEY_W-1:0] ka,
  input  logic [KEY_W-1:0] kb,
  input  probe_t           probe,
  output delta_t           delta
);

  logic             eq;
  logic [KEY_W-1:0] diff;
  logic [LZC_W-1:0] lz;
  delta_t           delta_calc;

  always_comb begin
    eq   = (ka == kb);
    diff = eq ? KEY_W'(probe.i ^ probe.j) : (ka ^ kb);
    lz   = lzc64(diff);
    if (!probe.inr) begin
      delta_calc = DELTA_NONE;
    end else if (eq) begin
      delta_calc = delta_t'({1'b0, lz}) + TIE_BONUS;
    end else begin
      delta_calc = delta_t'({1'b0, lz});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta <= delta_calc;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/radix_tree_node_builder.sv
// Radix tree internal node builder over sorted 64-bit keys in an on-chip key memory.
// A store request writes its key to the key memory. A build request reads the node key, runs P
// probes, P = 2 + 3 * log2(leaf_count) or so, and then posts the result.
// Each probe is one key memory read and one pass of the shared prefix length unit.
// A bad node index skips the search and goes straight to posting its result.
// Reset clears the sequencer and the output valid and sets leaf_count to 2; keys stay as they are.
`default_nettype none
module radix_tree_node_builder
  import rtnb_pkg::*;
#(
  parameter int MAX_LEAVES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,       // leaf_count
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // index[9:0], key[73:10]
  input  logic                  s_axis_tuser,   // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // node_index[9:0], left_child[19:10],
                                                // left_is_leaf[20], right_child[30:21],
                                                // right_is_leaf[31], range_end[41:32]
  output logic                  m_axis_tuser    // bad_index
);

  localparam int AW = $clog2(MAX_LEAVES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KI   = 3'd1;
  localparam logic [2:0] ST_DLT  = 3'd2;
  localparam logic [2:0] ST_EV   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [2:0] PH_DP   = 3'd0;
  localparam logic [2:0] PH_DM   = 3'd1;
  localparam logic [2:0] PH_LMAX = 3'd2;
  localparam logic [2:0] PH_BIN  = 3'd3;
  localparam logic [2:0] PH_DN   = 3'd4;
  localparam logic [2:0] PH_SPL  = 3'd5;

  logic [2:0]              st, st_next;
  logic [2:0]              ph, ph_next;
  logic [CNT_W-1:0]        n_q;
  logic [IDX_W-1:0]        i_q;
  logic                    bad_q;
  logic                    dir_neg, dir_neg_next;
  delta_t                  dp_q, dp_next;
  delta_t                  dmin_q, dmin_next;
  delta_t                  dnode_q, dnode_next;
  logic [OFF_W-1:0]        lmax_q, lmax_next;
  logic [OFF_W-1:0]        l_q, l_next;
  logic [OFF_W-1:0]        t_q, t_next;
  logic [OFF_W-1:0]        split_q, split_next;
  logic [OFF_W-1:0]        step_q, step_next;
  logic signed [POS_W-1:0] j_q, j_next;
  logic signed [POS_W-1:0] pos_q;
  logic                    inr_q;
  logic [KEY_W-1:0]        ki_q;

  logic                    in_acc;
  logic [IDX_W-1:0]        in_index;
  logic [KEY_W-1:0]        in_key;
  logic                    key_we;
  logic [AW-1:0]           raddr;
  logic [KEY_W-1:0]        rdata;
  delta_t                  delta_q;
  probe_t                  probe;

  logic                    neg;
  logic [OFF_W-1:0]        offs;
  logic signed [POS_W-1:0] i_ext;
  logic signed [POS_W-1:0] pos_calc;
  logic                    inr_calc;
  logic                    gt;
  logic                    load_out;

  logic signed [POS_W-1:0] fin;
  logic signed [POS_W-1:0] fin1;
  logic signed [POS_W-1:0] lo;
  logic signed [POS_W-1:0] hi;
  logic [OUT_USED_W-1:0]   res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (st == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_index      = s_axis_tdata[IDX_W-1:0];
  assign in_key        = s_axis_tdata[IDX_W +: KEY_W];
  assign key_we        = in_acc && (s_axis_tuser == ACT_STORE) && (32'(in_index) < MAX_LEAVES);

  assign i_ext    = signed'(POS_W'(i_q));
  assign pos_calc = neg ? (i_ext - signed'(POS_W'(offs))) : (i_ext + signed'(POS_W'(offs)));
  assign inr_calc = (pos_calc >= 0) && (pos_calc < signed'(POS_W'(n_q)));
  assign raddr    = (st == ST_IDLE) ? AW'(in_index) : AW'(pos_calc);
  assign gt       = (ph == PH_SPL) ? (delta_q > dnode_q) : (delta_q > dmin_q);
  assign load_out = (st == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  assign probe.inr = inr_q;
  assign probe.i   = CNT_W'(i_q);
  assign probe.j   = pos_q[CNT_W-1:0];

  rtnb_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_LEAVES)
  ) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (AW'(in_index)),
    .wdata (in_key),
    .raddr (raddr),
    .rdata (rdata)
  );

  rtnb_delta u_delta (
    .clk   (clk),
    .en    (st == ST_DLT),
    .ka    (ki_q),
    .kb    (rdata),
    .probe (probe),
    .delta (delta_q)
  );

  always_comb begin
    st_next      = st;
    ph_next      = ph;
    dir_neg_next = dir_neg;
    dp_next      = dp_q;
    dmin_next    = dmin_q;
    dnode_next   = dnode_q;
    lmax_next    = lmax_q;
    l_next       = l_q;
    t_next       = t_q;
    split_next   = split_q;
    step_next    = step_q;
    j_next       = j_q;
    neg          = dir_neg;
    offs         = '0;
    case (st)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == ACT_BUILD)) begin
          if (CNT_W'(in_index) >= n_q - CNT_W'(1)) begin
            st_next = ST_OUT;
          end else begin
            st_next = ST_KI;
          end
        end
      end
      ST_KI: begin
        neg     = 1'b0;
        offs    = OFF_W'(1);
        ph_next = PH_DP;
        st_next = ST_DLT;
      end
      ST_DLT: begin
        st_next = ST_EV;
      end
      ST_EV: begin
        st_next = ST_DLT;
        case (ph)
          PH_DP: begin
            dp_next = delta_q;
            neg     = 1'b1;
            offs    = OFF_W'(1);
            ph_next = PH_DM;
          end
          PH_DM: begin
            dir_neg_next = !(dp_q > delta_q);
            dmin_next    = dir_neg_next ? dp_q : delta_q;
            lmax_next    = OFF_W'(2);
            neg          = dir_neg_next;
            offs         = OFF_W'(2);
            ph_next      = PH_LMAX;
          end
          PH_LMAX: begin
            if (gt) begin
              lmax_next = lmax_q << 1;
              offs      = lmax_q << 1;
            end else begin
              t_next  = lmax_q >> 1;
              l_next  = '0;
              offs    = lmax_q >> 1;
              ph_next = PH_BIN;
            end
          end
          PH_BIN: begin
            l_next = gt ? (l_q + t_q) : l_q;
            t_next = t_q >> 1;
            if (t_next != '0) begin
              offs = l_next + t_next;
            end else begin
              offs    = l_next;
              ph_next = PH_DN;
            end
          end
          PH_DN: begin
            dnode_next = delta_q;
            j_next     = pos_q;
            split_next = '0;
            step_next  = (l_q + OFF_W'(1)) >> 1;
            offs       = step_next;
            ph_next    = PH_SPL;
          end
          PH_SPL: begin
            split_next = gt ? (split_q + step_q) : split_q;
            if (step_q > OFF_W'(1)) begin
              step_next = (step_q + OFF_W'(1)) >> 1;
              offs      = split_next + step_next;
            end else begin
              st_next = ST_OUT;
            end
          end
          default: begin
            st_next = ST_IDLE;
          end
        endcase
      end
      ST_OUT: begin
        if (load_out) st_next = ST_IDLE;
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    fin  = dir_neg ? (i_ext - signed'(POS_W'(split_q)) - POS_W'(1))
                   : (i_ext + signed'(POS_W'(split_q)));
    fin1 = fin + POS_W'(1);
    lo   = (i_ext < j_q) ? i_ext : j_q;
    hi   = (i_ext > j_q) ? i_ext : j_q;
    res  = {j_q[IDX_W-1:0], (hi == fin1), fin1[IDX_W-1:0],
            (lo == fin), fin[IDX_W-1:0], i_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      ph            <= PH_DP;
      n_q           <= MIN_LEAVES;
      m_axis_tvalid <= 1'b0;
    end else begin
      st <= st_next;
      ph <= ph_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_data < MIN_LEAVES) begin
          n_q <= MIN_LEAVES;
        end else if (32'(cfg_data) > MAX_LEAVES) begin
          n_q <= CNT_W'(MAX_LEAVES);
        end else begin
          n_q <= cfg_data;
        end
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dir_neg <= dir_neg_next;
    dp_q    <= dp_next;
    dmin_q  <= dmin_next;
    dnode_q <= dnode_next;
    lmax_q  <= lmax_next;
    l_q     <= l_next;
    t_q     <= t_next;
    split_q <= split_next;
    step_q  <= step_next;
    j_q     <= j_next;
    if (st == ST_IDLE && in_acc) begin
      i_q   <= in_index;
      bad_q <= (CNT_W'(in_index) >= n_q - CNT_W'(1));
    end
    if (st == ST_KI) begin
      ki_q <= rdata;
    end
    if (st == ST_KI || (st == ST_EV && st_next == ST_DLT)) begin
      pos_q <= pos_calc;
      inr_q <= inr_calc;
    end
    if (load_out) begin
      if (bad_q) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 1'b1;
      end else begin
        m_axis_tdata <= OUT_DATA_W'(res);
        m_axis_tuser <= 1'b0;
      end
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("bad index result carries nonzero fields");

  a_bin_step: assert property (@(posedge clk) disable iff (rst)
    st == ST_EV && ph == PH_BIN |-> t_q != '0)
    else $error("binary search step reached zero");

  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser == ACT_STORE |=> st == ST_IDLE)
    else $error("store request left the sequencer busy");

  a_node_range: assert property (@(posedge clk) disable iff (rst)
    (st == ST_KI || st == ST_DLT || st == ST_EV) |-> CNT_W'(i_q) < n_q - CNT_W'(1))
    else $error("search running on an out of range node");

endmodule
`default_nettype wire
